// ===== design/rth_pkg.sv =====
// shared constants and types of the rgb to hsl converter
package rth_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int HUE_BITS         = 11;
  localparam int HUE_FRAC_BITS    = 8;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_RED_WRAP,
    SEC_GREEN,
    SEC_BLUE
  } rth_sector_t;

endpackage

// ===== design/rth_prep.sv =====
// front stages: max, min, sector, lightness and divider operands
module rth_prep #(
  parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [CHANNEL_BITS-1:0]         red,
  input  logic [CHANNEL_BITS-1:0]         green,
  input  logic [CHANNEL_BITS-1:0]         blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [CHANNEL_BITS-1:0]         hue_rem,
  output logic [rth_pkg::HUE_BITS-1:0]    hue_q,
  output logic [CHANNEL_BITS-1:0]         hue_d,
  output logic [CHANNEL_BITS+1:0]         sat_rem,
  output logic [CHANNEL_BITS-1:0]         sat_q,
  output logic [CHANNEL_BITS+1:0]         sat_d,
  output logic [CHANNEL_BITS:0]           lit,
  output logic                            grey
);
  import rth_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam logic [CB:0] FULL = {1'b0, {CB{1'b1}}};

  // stage one
  logic              v1;
  logic              ready1;
  logic [CB-1:0]     d1;
  logic [CB:0]       sum1;
  logic [CB:0]       off1;
  rth_sector_t       sec1;

  logic [CB-1:0]     mx;
  logic [CB-1:0]     mn;
  rth_sector_t       sec_next;
  logic [CB:0]       off_next;

  // stage two
  logic              ready2;
  logic [CB+2:0]     kd;
  logic [CB+3:0]     num_w;
  logic [CB+2:0]     num;
  logic [CB:0]       den_w;
  logic [CB-1:0]     den;
  logic [2*CB+1:0]   n_sat;

  assign ready2   = !out_valid || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    if (red == mx) begin
      sec_next = (green < blue) ? SEC_RED_WRAP : SEC_RED;
      off_next = {1'b0, green} - {1'b0, blue};
    end else if (green == mx) begin
      sec_next = SEC_GREEN;
      off_next = {1'b0, blue} - {1'b0, red};
    end else begin
      sec_next = SEC_BLUE;
      off_next = {1'b0, red} - {1'b0, green};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      d1   <= mx - mn;
      sum1 <= {1'b0, mx} + {1'b0, mn};
      off1 <= off_next;
      sec1 <= sec_next;
    end
  end

  always_comb begin
    unique case (sec1)
      SEC_RED:      kd = '0;
      SEC_RED_WRAP: kd = {1'b0, d1, 2'b00} + {2'b00, d1, 1'b0};
      SEC_GREEN:    kd = {2'b00, d1, 1'b0};
      SEC_BLUE:     kd = {1'b0, d1, 2'b00};
      default:      kd = '0;
    endcase
    num_w = {1'b0, kd} + {{3{off1[CB]}}, off1};
    num   = num_w[CB+2:0];
    den_w = (sum1 > FULL) ? ({FULL[CB-1:0], 1'b0} - sum1) : sum1;
    den   = den_w[CB-1:0];
    n_sat = {1'b0, d1, {(CB+1){1'b0}}} - {{(CB+1){1'b0}}, d1, 1'b0}
          + {{(CB+2){1'b0}}, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      hue_rem <= num[CB+2:3];
      hue_q   <= {num[2:0], {HUE_FRAC_BITS{1'b0}}};
      hue_d   <= d1;
      sat_rem <= n_sat[2*CB+1:CB];
      sat_q   <= n_sat[CB-1:0];
      sat_d   <= {1'b0, den, 1'b0};
      lit     <= sum1;
      grey    <= (d1 == '0);
    end
  end

endmodule

// ===== design/rth_cell.sv =====
// one divider cell: one quotient bit of hue and of saturation per beat, each only where its enable is set
module rth_cell #(
  parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF,
  parameter bit HUE_EN       = 1'b1,
  parameter bit SAT_EN       = 1'b1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [CHANNEL_BITS-1:0]         hue_rem_in,
  input  logic [rth_pkg::HUE_BITS-1:0]    hue_q_in,
  input  logic [CHANNEL_BITS-1:0]         hue_d_in,
  input  logic [CHANNEL_BITS+1:0]         sat_rem_in,
  input  logic [CHANNEL_BITS-1:0]         sat_q_in,
  input  logic [CHANNEL_BITS+1:0]         sat_d_in,
  input  logic [CHANNEL_BITS:0]           lit_in,
  input  logic                            grey_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [CHANNEL_BITS-1:0]         hue_rem,
  output logic [rth_pkg::HUE_BITS-1:0]    hue_q,
  output logic [CHANNEL_BITS-1:0]         hue_d,
  output logic [CHANNEL_BITS+1:0]         sat_rem,
  output logic [CHANNEL_BITS-1:0]         sat_q,
  output logic [CHANNEL_BITS+1:0]         sat_d,
  output logic [CHANNEL_BITS:0]           lit,
  output logic                            grey
);
  import rth_pkg::*;

  localparam int CB = CHANNEL_BITS;

  logic [CB-1:0]       hue_rem_next;
  logic [HUE_BITS-1:0] hue_q_next;
  logic [CB+1:0]       sat_rem_next;
  logic [CB-1:0]       sat_q_next;

  assign in_ready = !out_valid || out_ready;

  generate
    if (HUE_EN) begin : g_hue
      logic [CB:0] cand;
      logic [CB:0] diff;
      logic        ge;
      always_comb begin
        cand         = {hue_rem_in, hue_q_in[HUE_BITS-1]};
        ge           = (cand >= {1'b0, hue_d_in});
        diff         = cand - {1'b0, hue_d_in};
        hue_rem_next = ge ? diff[CB-1:0] : cand[CB-1:0];
        hue_q_next   = {hue_q_in[HUE_BITS-2:0], ge};
      end
    end else begin : g_hue_pass
      assign hue_rem_next = hue_rem_in;
      assign hue_q_next   = hue_q_in;
    end

    if (SAT_EN) begin : g_sat
      logic [CB+2:0] cand;
      logic [CB+2:0] diff;
      logic          ge;
      always_comb begin
        cand         = {sat_rem_in, sat_q_in[CB-1]};
        ge           = (cand >= {1'b0, sat_d_in});
        diff         = cand - {1'b0, sat_d_in};
        sat_rem_next = ge ? diff[CB+1:0] : cand[CB+1:0];
        sat_q_next   = {sat_q_in[CB-2:0], ge};
      end
    end else begin : g_sat_pass
      assign sat_rem_next = sat_rem_in;
      assign sat_q_next   = sat_q_in;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue_rem <= hue_rem_next;
      hue_q   <= hue_q_next;
      hue_d   <= hue_d_in;
      sat_rem <= sat_rem_next;
      sat_q   <= sat_q_next;
      sat_d   <= sat_d_in;
      lit     <= lit_in;
      grey    <= grey_in;
    end
  end

endmodule

// ===== design/rgb_to_hsl.sv =====
// rgb to hsl converter top level: front stages and a row of divider cells
//
//   channel  dir  fields (low bit up)
//   s_axis   in   red, green, blue
//   m_axis   out  hue, saturation, lightness
//
// one beat per cycle sustained while the output is not stalled; a beat passes the front
// stages and then the row of divider cells, one quotient bit per cell.
// every stage holds its own valid bit, so a stalled output lets empty stages
// upstream keep filling; reset clears only the valid bits.
module rgb_to_hsl #(
  parameter int CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // red, green, blue
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]          s_tdata,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // hue, saturation, lightness
  output logic [((2*CHANNEL_BITS+rth_pkg::HUE_BITS+1+7)/8)*8-1:0] m_tdata
);
  import rth_pkg::*;

  localparam int CB    = CHANNEL_BITS;
  localparam int NSTEP = (HUE_BITS > CB) ? HUE_BITS : CB;
  localparam int OUT_W = ((2*CB+HUE_BITS+1+7)/8)*8;

  logic [NSTEP:0]                valid;
  logic [NSTEP:0]                ready;
  logic [NSTEP:0][CB-1:0]        hue_rem;
  logic [NSTEP:0][HUE_BITS-1:0]  hue_q;
  logic [NSTEP:0][CB-1:0]        hue_d;
  logic [NSTEP:0][CB+1:0]        sat_rem;
  logic [NSTEP:0][CB-1:0]        sat_q;
  logic [NSTEP:0][CB+1:0]        sat_d;
  logic [NSTEP:0][CB:0]          lit;
  logic [NSTEP:0]                grey;

  logic [HUE_BITS-1:0]           hue_out;
  logic [CB-1:0]                 sat_out;

  rth_prep #(
    .CHANNEL_BITS(CB)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .red      (s_tdata[CB-1:0]),
    .green    (s_tdata[2*CB-1:CB]),
    .blue     (s_tdata[3*CB-1:2*CB]),
    .out_valid(valid[0]),
    .out_ready(ready[0]),
    .hue_rem  (hue_rem[0]),
    .hue_q    (hue_q[0]),
    .hue_d    (hue_d[0]),
    .sat_rem  (sat_rem[0]),
    .sat_q    (sat_q[0]),
    .sat_d    (sat_d[0]),
    .lit      (lit[0]),
    .grey     (grey[0])
  );

  generate
    for (genvar i = 0; i < NSTEP; i++) begin : g_cell
      rth_cell #(
        .CHANNEL_BITS(CB),
        .HUE_EN      (i < HUE_BITS),
        .SAT_EN      (i < CB)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (valid[i]),
        .in_ready  (ready[i]),
        .hue_rem_in(hue_rem[i]),
        .hue_q_in  (hue_q[i]),
        .hue_d_in  (hue_d[i]),
        .sat_rem_in(sat_rem[i]),
        .sat_q_in  (sat_q[i]),
        .sat_d_in  (sat_d[i]),
        .lit_in    (lit[i]),
        .grey_in   (grey[i]),
        .out_valid (valid[i+1]),
        .out_ready (ready[i+1]),
        .hue_rem   (hue_rem[i+1]),
        .hue_q     (hue_q[i+1]),
        .hue_d     (hue_d[i+1]),
        .sat_rem   (sat_rem[i+1]),
        .sat_q     (sat_q[i+1]),
        .sat_d     (sat_d[i+1]),
        .lit       (lit[i+1]),
        .grey      (grey[i+1])
      );
    end
  endgenerate

  assign ready[NSTEP] = m_tready;
  assign m_tvalid     = valid[NSTEP];

  // grey pixels carry no hue or saturation
  assign hue_out = grey[NSTEP] ? '0 : hue_q[NSTEP];
  assign sat_out = grey[NSTEP] ? '0 : sat_q[NSTEP];
  assign m_tdata = OUT_W'({lit[NSTEP], sat_out, hue_out});

endmodule

// ===== tb/hsl_checker.sv =====
// scoreboard for the rgb to hsl converter: predicts each pixel beat and checks the result beats
module hsl_checker #(
  parameter int CB = rth_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  input  logic                                          s_tready,
  // red, green, blue
  input  logic [((3*CB+7)/8)*8-1:0]                     s_tdata,
  input  logic                                          m_tvalid,
  input  logic                                          m_tready,
  // hue, saturation, lightness
  input  logic [((2*CB+rth_pkg::HUE_BITS+1+7)/8)*8-1:0] m_tdata,
  output int                                            errors,
  output int                                            pending,
  output int                                            n_done,
  output int                                            n_grey
);
  timeunit 1ns;
  timeprecision 1ps;
  import rth_pkg::*;

  localparam int FULL = (1 << CB) - 1;

  typedef struct packed {
    logic [CB:0]          light;
    logic [CB-1:0]        sat;
    logic [HUE_BITS-1:0]  hue;
  } hsl_t;

  hsl_t hsl_q[$];
  int   fails = 0;
  int   done  = 0;
  int   grey  = 0;

  function automatic hsl_t hsl_of(int unsigned r, int unsigned g, int unsigned b);
    int unsigned mx, mn, d, den, num;
    rth_sector_t sec;
    hsl_t res;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    res.light = (CB+1)'(mx + mn);
    res.hue = '0;
    res.sat = '0;
    if (d != 0) begin
      den = (mx + mn > FULL) ? 2 * FULL - mx - mn : mx + mn;
      res.sat = CB'((2 * FULL * d + den) / (2 * den));
      // ties go to red first, then green
      if (r == mx) sec = (g < b) ? SEC_RED_WRAP : SEC_RED;
      else if (g == mx) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      case (sec)
        SEC_RED:      num = g - b;
        SEC_RED_WRAP: num = 6 * d - (b - g);
        SEC_GREEN:    num = 2 * d + b - r;
        default:      num = 4 * d + r - g;
      endcase
      res.hue = HUE_BITS'((256 * num) / d);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    hsl_t got;
    hsl_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(hsl_t)-1:0];
        if (hsl_q.size() == 0) begin
          fails++;
          $error("result beat with no pixel waiting: tdata %h", m_tdata);
        end else begin
          want = hsl_q.pop_front();
          if (got.hue !== want.hue) begin
            fails++;
            $error("hue: expected %0d, actual %0d", want.hue, got.hue);
          end
          if (got.sat !== want.sat) begin
            fails++;
            $error("saturation: expected %0d, actual %0d", want.sat, got.sat);
          end
          if (got.light !== want.light) begin
            fails++;
            $error("lightness: expected %0d, actual %0d", want.light, got.light);
          end
          done++;
        end
      end
      if (s_tvalid && s_tready) begin
        hsl_q.push_back(hsl_of(32'(s_tdata[CB-1:0]), 32'(s_tdata[2*CB-1:CB]),
                               32'(s_tdata[3*CB-1:2*CB])));
        if (s_tdata[CB-1:0] == s_tdata[2*CB-1:CB] && s_tdata[CB-1:0] == s_tdata[3*CB-1:2*CB])
          grey++;
      end
    end
    errors  <= fails;
    pending <= hsl_q.size();
    n_done  <= done;
    n_grey  <= grey;
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the rgb to hsl testbench: clock, reset, pixel stimulus, ready pattern and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rth_pkg::*;

  localparam int CB             = CHANNEL_BITS_DEF;
  localparam int FULL           = (1 << CB) - 1;
  localparam int IN_W           = ((3*CB+7)/8)*8;
  localparam int LIMIT          = 200000;
  localparam int RANDOM_PER_MIX = 420;
  localparam int DRAIN_CYCLES   = 2 + HUE_BITS + CB + 8;

  typedef struct packed {
    logic [CB-1:0] blue;
    logic [CB-1:0] green;
    logic [CB-1:0] red;
  } pixel_t;

  logic clk      = 1'b0;
  logic rst      = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [((2*CB+HUE_BITS+1+7)/8)*8-1:0] m_tdata;

  int errors, pending, n_done, n_grey;
  int cycles    = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int n_sent    = 0;
  int n_directed;
  int send_idle_pct [3] = '{9, 61, 0};
  int recv_idle_pct [3] = '{61, 9, 0};

  rgb_to_hsl u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  hsl_checker #(.CB(CB)) u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending),
    .n_done   (n_done),
    .n_grey   (n_grey)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [CB-1:0] extreme_chan();
    case ($urandom_range(3))
      0:       return '0;
      1:       return CB'(1);
      2:       return CB'(FULL - 1);
      default: return CB'(FULL);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    logic [CB-1:0] v;
    p = (3*CB)'($urandom);
    v = CB'($urandom);
    case ($urandom_range(9))
      0: p = '{v, v, v};
      1: p.green = p.red;
      2: p.blue = p.red;
      3: p.blue = p.green;
      4: p = '{extreme_chan(), extreme_chan(), extreme_chan()};
      default: ;
    endcase
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_pixel(input int r, input int g, input int b);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({CB'(b), CB'(g), CB'(r)});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    pixel_t p;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle = send_idle_pct[0];
    recv_idle = recv_idle_pct[0];

    // corners, primaries, ties between channels, wrap sector, rounding half
    send_pixel(0, 0, 0);
    send_pixel(FULL, FULL, FULL);
    send_pixel(128, 128, 128);
    send_pixel(FULL, 0, 0);
    send_pixel(0, FULL, 0);
    send_pixel(0, 0, FULL);
    send_pixel(FULL, FULL, 0);
    send_pixel(0, FULL, FULL);
    send_pixel(FULL, 0, FULL);
    send_pixel(FULL, 0, 1);
    send_pixel(FULL, 1, 0);
    send_pixel(200, 200, 10);
    send_pixel(10, 200, 200);
    send_pixel(200, 10, 200);
    send_pixel(3, 1, 1);
    send_pixel(FULL, 1, 1);
    send_pixel(128, 127, 127);
    send_pixel(1, 0, 0);
    send_pixel(0, 1, FULL - 1);
    send_pixel(FULL - 1, FULL, 0);
    send_pixel(170, 85, 0);
    send_pixel(17, 204, 90);
    n_directed = n_sent;
    drain();

    for (int mix = 0; mix < 3; mix++) begin
      send_idle = send_idle_pct[mix];
      recv_idle = recv_idle_pct[mix];
      for (int i = 0; i < RANDOM_PER_MIX; i++) begin
        p = rand_pixel();
        send_pixel(int'(p.red), int'(p.green), int'(p.blue));
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d pixels converted (%0d directed, %0d grey) across sparse, stalled and",
             n_done, n_directed, n_grey);
    $display("back-to-back handshake mixes");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rth_pkg.sv
design/rth_prep.sv
design/rth_cell.sv
design/rgb_to_hsl.sv
tb/hsl_checker.sv
tb/tb_top.sv
